// File: design/ufrb_pkg.sv
// Shared types and constants of the UART FIFO register block.
package ufrb_pkg;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;
   localparam logic [1:0] REQ_LINE  = 2'd3;

   localparam logic [5:0] A_URXD = 6'd0;
   localparam logic [5:0] A_UTXD = 6'd16;
   localparam logic [5:0] A_UCR1 = 6'd32;
   localparam logic [5:0] A_UCR2 = 6'd33;
   localparam logic [5:0] A_UCR3 = 6'd34;
   localparam logic [5:0] A_UCR4 = 6'd35;
   localparam logic [5:0] A_UFCR = 6'd36;
   localparam logic [5:0] A_USR1 = 6'd37;
   localparam logic [5:0] A_USR2 = 6'd38;
   localparam logic [5:0] A_UBRC = 6'd43;
   localparam logic [5:0] A_UTS  = 6'd45;

   localparam int MAX_DRAIN = 32;

   // enable bit positions
   localparam int EN_UART = 0;
   localparam int EN_RX   = 1;
   localparam int EN_TX   = 2;
   localparam int EN_WS8  = 3;
   localparam int EN_TRDY = 4;
   localparam int EN_RRDY = 5;
   localparam int EN_TXMT = 6;
   localparam int EN_TC   = 7;
   localparam int EN_DR   = 8;

   // status flag positions
   localparam int F_RDR  = 0;
   localparam int F_RRDY = 1;
   localparam int F_TXFE = 2;
   localparam int F_TXDC = 3;
   localparam int F_TRDY = 4;

   typedef struct packed {
      logic [31:0] read_data;
      logic        tx_valid;
      logic [7:0]  tx_char;
      logic        irq_level;
      logic        last;
   } rsp_type;

endpackage

// File: design/uart_fifo_register_block_unit.sv
// Top level of the UART FIFO register block: request decode and sequencing.
// A bus access or line byte passes the execute state and the output register to its result.
// A tick emits one character per cycle while the output is free, up to 32 results; one item in flight.
// A new request is taken only once the sequencer is back in idle.
// Pace set by the registered memory read before each decision.
// Reset: synchronous; FIFOs empty, enables clear, txfe/txdc set, registers zero.
module uart_fifo_register_block_unit #(
   parameter int FIFO_DEPTH = 32,
   parameter int REG_WORDS  = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // req_type[1:0], bus_addr[7:2], write_data[39:8], line_byte[47:40]
   input  logic [47:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // read_data[31:0], tx_valid[32], tx_char[40:33], irq_level[41], pad
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast
);
   localparam int CW = $clog2(FIFO_DEPTH+1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [1:0]  rtype_ff;
   logic [5:0]  addr_ff;
   logic [31:0] wdata_ff;
   logic [7:0]  lbyte_ff;
   logic [8:0]  en_ff, en_in;
   logic [4:0]  flags_ff, flags_in;
   logic [4:0]  rxm_ff, rxm_in, txm_ff, txm_in;
   logic [5:0]  ndrain_ff, ndrain_in;
   logic        uts5_ff, uts5_in;
   ufrb_pkg::rsp_type out_ff, out_in;
   logic        out_v_ff, out_v_in;

   logic [CW-1:0] rx_cnt, tx_cnt;
   logic [7:0]    rx_head, tx_head;
   logic          rx_push, rx_pop, tx_push, tx_pop, flush;
   logic          rg_we;
   logic [5:0]    rg_wa;
   logic [31:0]   rg_wd, rg_rd;

   logic take;
   assign take       = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   function automatic logic [7:0] mask8();
      mask8 = en_ff[ufrb_pkg::EN_WS8] ? 8'hFF : 8'h7F;
   endfunction

   // capture the request
   always_ff @(posedge clock) begin
      if (take) begin
         rtype_ff <= req_tdata[1:0];
         addr_ff  <= req_tdata[7:2];
         wdata_ff <= req_tdata[39:8];
         lbyte_ff <= req_tdata[47:40];
      end
   end

   ufrb_fifo #(.DEPTH(FIFO_DEPTH)) u_rx (
      .clock, .reset, .push(rx_push), .push_data(lbyte_ff & mask8()),
      .pop(rx_pop), .flush, .count(rx_cnt), .head_data(rx_head));
   ufrb_fifo #(.DEPTH(FIFO_DEPTH)) u_tx (
      .clock, .reset, .push(tx_push), .push_data(wdata_ff[7:0] & mask8()),
      .pop(tx_pop), .flush, .count(tx_cnt), .head_data(tx_head));
   // read address from the request word when taken, then the captured address while it executes
   ufrb_regs #(.WORDS(REG_WORDS)) u_regs (
      .clock, .reset, .wr_en(rg_we), .wr_addr(rg_wa), .wr_data(rg_wd),
      .rd_addr(take ? req_tdata[7:2] : addr_ff), .rd_data(rg_rd));

   // flags from given counts
   function automatic logic [4:0] calc_flags(input logic [CW-1:0] rc,
                                             input logic [CW-1:0] tc);
      logic [4:0] f;
      f = '0;
      f[ufrb_pkg::F_RDR]  = (rc != '0);
      f[ufrb_pkg::F_RRDY] = (32'(rc) > 32'(rxm_ff));
      f[ufrb_pkg::F_TXFE] = (tc == '0);
      f[ufrb_pkg::F_TXDC] = (tc == '0);
      f[ufrb_pkg::F_TRDY] = (32'(tc) < 32'(txm_ff));
      calc_flags = f;
   endfunction

   function automatic logic irq_of(input logic [8:0] e, input logic [4:0] f);
      irq_of = (e[ufrb_pkg::EN_RRDY] && f[ufrb_pkg::F_RRDY])
            || (e[ufrb_pkg::EN_TXMT] && f[ufrb_pkg::F_TXFE])
            || (e[ufrb_pkg::EN_TRDY] && f[ufrb_pkg::F_TRDY])
            || (e[ufrb_pkg::EN_TC]   && f[ufrb_pkg::F_TXDC])
            || (e[ufrb_pkg::EN_DR]   && f[ufrb_pkg::F_RDR]);
   endfunction

   logic out_free;
   assign out_free = !out_v_ff || rsp_tready;

   // sequencer
   always_comb begin
      logic [CW-1:0] nrx, ntx;
      logic [31:0]   rd;
      logic          recompute;
      state_in  = state_ff;
      en_in     = en_ff;
      flags_in  = flags_ff;
      rxm_in    = rxm_ff;
      txm_in    = txm_ff;
      ndrain_in = ndrain_ff;
      uts5_in   = uts5_ff;
      out_in    = out_ff;
      out_v_in  = out_v_ff && !rsp_tready;
      rx_push = 1'b0; rx_pop = 1'b0; tx_push = 1'b0; tx_pop = 1'b0;
      flush = 1'b0;
      rg_we = 1'b0; rg_wa = addr_ff; rg_wd = wdata_ff;
      nrx = rx_cnt; ntx = tx_cnt; rd = '0; recompute = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (take) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
               case (rtype_ff)
                  ufrb_pkg::REQ_TICK: begin
                     if (en_ff[ufrb_pkg::EN_UART]) begin
                        if (en_ff[ufrb_pkg::EN_TX] && tx_cnt != '0) begin
                           state_in  = S_DRAIN;
                           ndrain_in = '0;
                        end else recompute = 1'b1;
                     end
                  end
                  ufrb_pkg::REQ_READ: begin
                     case (addr_ff)
                        ufrb_pkg::A_URXD: begin
                           if (en_ff[ufrb_pkg::EN_UART] && en_ff[ufrb_pkg::EN_RX]
                               && rx_cnt != '0) begin
                              rd = {16'd0, 8'h80, rx_head};
                              rx_pop = 1'b1; nrx = rx_cnt - 1'b1;
                              recompute = 1'b1;
                           end
                        end
                        ufrb_pkg::A_USR1:
                           rd = {18'd0, flags_ff[ufrb_pkg::F_TRDY], 3'd0,
                                 flags_ff[ufrb_pkg::F_RRDY], 9'd0};
                        ufrb_pkg::A_USR2:
                           rd = {17'd0, flags_ff[ufrb_pkg::F_TXFE], 10'd0,
                                 flags_ff[ufrb_pkg::F_TXDC], 2'd0,
                                 flags_ff[ufrb_pkg::F_RDR]};
                        default: begin
                           rd = rg_rd;
                           // UTS bit 5 is kept beside the store
                           if (addr_ff == ufrb_pkg::A_UTS) rd[5] = uts5_ff;
                        end
                     endcase
                  end
                  ufrb_pkg::REQ_WRITE: begin
                     case (addr_ff)
                        ufrb_pkg::A_UTXD: begin
                           if (en_ff[ufrb_pkg::EN_UART] && en_ff[ufrb_pkg::EN_TX]
                               && 32'(tx_cnt) < 32'(FIFO_DEPTH)) begin
                              tx_push = 1'b1; ntx = tx_cnt + 1'b1;
                              recompute = 1'b1;
                           end
                        end
                        ufrb_pkg::A_UCR1: begin
                           en_in[ufrb_pkg::EN_TRDY] = wdata_ff[13];
                           en_in[ufrb_pkg::EN_RRDY] = wdata_ff[9];
                           en_in[ufrb_pkg::EN_TXMT] = wdata_ff[6];
                           en_in[ufrb_pkg::EN_UART] = wdata_ff[0];
                           rg_we = 1'b1; rg_wd = wdata_ff & 32'hFFEF;
                        end
                        ufrb_pkg::A_UCR2: begin
                           if (wdata_ff[0]) begin
                              flush = 1'b1; nrx = '0; ntx = '0;
                              recompute = 1'b1;
                           end
                           en_in[ufrb_pkg::EN_WS8] = wdata_ff[5];
                           en_in[ufrb_pkg::EN_TX]  = wdata_ff[2];
                           en_in[ufrb_pkg::EN_RX]  = wdata_ff[1];
                           rg_we = 1'b1; rg_wd = (wdata_ff & 32'hFFFE) | 32'd1;
                        end
                        ufrb_pkg::A_UCR3: begin
                           rg_we = 1'b1; rg_wd = wdata_ff & 32'hFFFF;
                        end
                        ufrb_pkg::A_UCR4: begin
                           en_in[ufrb_pkg::EN_TC] = wdata_ff[3];
                           en_in[ufrb_pkg::EN_DR] = wdata_ff[0];
                           rg_we = 1'b1; rg_wd = wdata_ff & 32'hFFFF;
                        end
                        ufrb_pkg::A_UFCR: begin
                           txm_in = wdata_ff[14:10];
                           rxm_in = wdata_ff[4:0];
                           rg_we = 1'b1; rg_wd = wdata_ff & 32'hFFFF;
                        end
                        ufrb_pkg::A_USR1, ufrb_pkg::A_USR2, ufrb_pkg::A_UBRC: ;
                        default: begin
                           rg_we = 1'b1;
                           if (addr_ff == ufrb_pkg::A_UTS) uts5_in = wdata_ff[5];
                        end
                     endcase
                  end
                  default: begin
                     if (en_ff[ufrb_pkg::EN_UART] && en_ff[ufrb_pkg::EN_RX]
                         && 32'(rx_cnt) < 32'(FIFO_DEPTH))
                        rx_push = 1'b1;
                  end
               endcase
               if (recompute) begin
                  flags_in = calc_flags(nrx, ntx);
                  uts5_in  = (nrx == '0);
               end
               if (state_in == S_IDLE) begin
                  out_v_in = 1'b1;
                  out_in.read_data = rd;
                  out_in.tx_valid  = 1'b0;
                  out_in.tx_char   = '0;
                  out_in.irq_level = irq_of(en_in, flags_in);
                  out_in.last      = 1'b1;
               end
            end
         end
         S_DRAIN: begin
            // one character per cycle while the output slot is free
            if (out_free) begin
               tx_pop = 1'b1; ntx = tx_cnt - 1'b1;
               flags_in = calc_flags(rx_cnt, ntx);
               uts5_in  = (rx_cnt == '0);
               ndrain_in = ndrain_ff + 1'b1;
               out_v_in = 1'b1;
               out_in.read_data = '0;
               out_in.tx_valid  = 1'b1;
               out_in.tx_char   = tx_head & mask8();
               out_in.irq_level = irq_of(en_ff, flags_in);
               out_in.last      = (ntx == '0) || (ndrain_ff == 6'(ufrb_pkg::MAX_DRAIN-1));
               if (out_in.last) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         en_ff     <= '0;
         flags_ff  <= 5'b01100;
         rxm_ff    <= '0;
         txm_ff    <= '0;
         ndrain_ff <= '0;
         uts5_ff   <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         en_ff     <= en_in;
         flags_ff  <= flags_in;
         rxm_ff    <= rxm_in;
         txm_ff    <= txm_in;
         ndrain_ff <= ndrain_in;
         uts5_ff   <= uts5_in;
         out_v_ff  <= out_v_in;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {6'd0, out_ff.irq_level, out_ff.tx_char,
                        out_ff.tx_valid, out_ff.read_data};

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      !(take && state_ff != S_IDLE))
      else $error("request taken while busy");
   a_char_valid: assert property (@(posedge clock) disable iff (reset)
      !(rsp_tvalid && !out_ff.tx_valid && out_ff.tx_char != '0))
      else $error("character without tx_valid");
   a_drain_fill: assert property (@(posedge clock) disable iff (reset)
      !(state_ff == S_DRAIN && tx_cnt == '0))
      else $error("drain with empty transmit fifo");
endmodule

// File: design/ufrb_fifo.sv
// Byte FIFO held in a synchronous memory with a registered read.
module ufrb_fifo #(
   parameter int DEPTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [7:0]                 push_data,
   input  logic                       pop,
   input  logic                       flush,
   output logic [$clog2(DEPTH+1)-1:0] count,
   output logic [7:0]                 head_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [7:0]    mem [DEPTH];
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
      bump = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // pointer and count update
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (flush) begin
         rd_ptr_in = '0;
         wr_ptr_in = '0;
         count_in  = '0;
      end else begin
         if (push) wr_ptr_in = bump(wr_ptr_ff);
         if (pop)  rd_ptr_in = bump(rd_ptr_ff);
         count_in = count_ff + CW'(push) - CW'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // memory: write at tail, registered read of the next head
   always_ff @(posedge clock) begin
      if (push && !flush) mem[wr_ptr_ff] <= push_data;
   end

   logic [7:0] rd_data_ff;
   logic       fwd_ff;
   logic [7:0] fwd_data_ff;
   always_ff @(posedge clock) begin
      rd_data_ff  <= mem[rd_ptr_in];
      // forward a push that lands on the head address this cycle
      fwd_ff      <= push && !flush && (wr_ptr_ff == rd_ptr_in);
      fwd_data_ff <= push_data;
   end

   assign head_data = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign count     = count_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("fifo count above depth");
   a_pop_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && !flush && count_ff == '0))
      else $error("pop of empty fifo");
   a_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && !flush && count_ff == CW'(DEPTH)))
      else $error("push into full fifo");
endmodule

// File: design/ufrb_regs.sv
// Register store in a synchronous memory, entries valid once written.
module ufrb_regs #(
   parameter int WORDS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [5:0]  wr_addr,
   input  logic [31:0] wr_data,
   input  logic [5:0]  rd_addr,
   output logic [31:0] rd_data
);
   localparam int SPAN = (WORDS < 64) ? WORDS : 64;

   logic [31:0]     mem [SPAN];
   logic [SPAN-1:0] valid_ff;
   logic [31:0]     rd_data_ff;
   logic            rd_ok_ff;
   logic            in_wr, in_rd;

   assign in_wr = (32'(wr_addr) < 32'(SPAN));
   assign in_rd = (32'(rd_addr) < 32'(SPAN));

   always_ff @(posedge clock) begin
      if (wr_en && in_wr) mem[wr_addr[$clog2(SPAN)-1:0]] <= wr_data;
      rd_data_ff <= mem[rd_addr[$clog2(SPAN)-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en && in_wr) valid_ff[wr_addr[$clog2(SPAN)-1:0]] <= 1'b1;
         rd_ok_ff <= in_rd && valid_ff[rd_addr[$clog2(SPAN)-1:0]];
      end
   end

   assign rd_data = rd_ok_ff ? rd_data_ff : 32'd0;
endmodule
